// ===== design/odq_pkg.sv =====
// odq_pkg: shared types, constants and the Bayer threshold table for the
// ordered-dither color quantizer. No dependencies.

package odq_pkg;

    localparam int STG_NUM   = 10;  // input stage, eight lane stages, output stage
    localparam int LANE_STG  = 8;
    localparam int DIV_STG   = 4;
    localparam int DIV_BITS  = 2;
    localparam int CH_NUM    = 3;

    localparam logic [1:0] CFG_QUANT_EN = 2'd0;
    localparam logic [1:0] CFG_LEVELS   = 2'd1;
    localparam logic [1:0] CFG_SCALE    = 2'd2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
        logic [1:0] dither_col;
        logic [1:0] dither_row;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    typedef struct packed {
        logic [LANE_STG-1:0] adv;
        logic [8:0]          lm1;
        logic [10:0]         dmag;
        logic                dneg;
    } t_lane_ctrl;

    typedef struct packed {
        logic quant_en;
        logic zero_out;
        logic adv;
    } t_merge_ctrl;

    function automatic logic [3:0] bayer_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] v;
        case ({row, col})
            4'h0: v = 4'd0;
            4'h1: v = 4'd8;
            4'h2: v = 4'd2;
            4'h3: v = 4'd10;
            4'h4: v = 4'd12;
            4'h5: v = 4'd4;
            4'h6: v = 4'd14;
            4'h7: v = 4'd6;
            4'h8: v = 4'd3;
            4'h9: v = 4'd11;
            4'hA: v = 4'd1;
            4'hB: v = 4'd9;
            4'hC: v = 4'd15;
            4'hD: v = 4'd7;
            4'hE: v = 4'd13;
            4'hF: v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/odq_lane.sv =====
// odq_lane: one color channel lane: dither add and clamp, quantize by 255,
// and re-expand through a pipelined restoring divider. Depends on odq_pkg.

module odq_lane import odq_pkg::*; (
    input  logic       i_clk,
    input  t_lane_ctrl i_ctrl,
    input  logic [7:0] i_value,
    output logic [7:0] o_quo,
    output logic [7:0] o_raw
);

    logic [7:0]  r_raw [LANE_STG];
    logic [17:0] r_x1;
    logic [17:0] r_x2;
    logic [8:0]  r_q0;
    logic [8:0]  r_q;
    logic [16:0] r_drem [DIV_STG+1];
    logic [7:0]  r_dquo [DIV_STG+1];

    logic [11:0] sum_up;
    logic        under;
    logic [7:0]  v;
    logic [17:0] n_x1;
    logic [25:0] y;
    logic [8:0]  n_q0;
    logic [16:0] p;
    logic [17:0] rem;
    logic [8:0]  n_q;
    logic [16:0] n_num;
    logic [16:0] n_drem [DIV_STG];
    logic [7:0]  n_dquo [DIV_STG];

    // dither add with clamp, then v * (levels - 1) + 127
    always_comb begin
        sum_up = 12'(i_value) + 12'(i_ctrl.dmag);
        under  = i_ctrl.dmag > 11'(i_value);
        if (i_ctrl.dneg) begin
            v = under ? 8'd0 : (i_value - i_ctrl.dmag[7:0]);
        end else begin
            v = (sum_up > 12'd255) ? 8'd255 : sum_up[7:0];
        end
        n_x1 = 18'(v) * 18'(i_ctrl.lm1) + 18'd127;
    end

    // divide by 255: estimate with x * 257 >> 16, then one correction
    always_comb begin
        y     = 26'(r_x1) + {r_x1, 8'b0};
        n_q0  = y[24:16];
        p     = {r_q0, 8'b0} - 17'(r_q0);
        rem   = r_x2 - 18'(p);
        n_q   = r_q0 + 9'(rem >= 18'd255);
        n_num = {r_q, 8'b0} - 17'(r_q) + 17'(i_ctrl.lm1[8:1]);
    end

    // restoring divide by levels - 1, two quotient bits per stage
    always_comb begin
        logic [16:0] drem;
        logic [7:0]  dquo;
        logic [16:0] dsh;
        logic        ge;
        for (int d = 0; d < DIV_STG; d++) begin
            drem = r_drem[d];
            dquo = r_dquo[d];
            for (int s = 0; s < DIV_BITS; s++) begin
                dsh  = 17'(i_ctrl.lm1) << (7 - DIV_BITS * d - s);
                ge   = drem >= dsh;
                drem = ge ? (drem - dsh) : drem;
                dquo = {dquo[6:0], ge};
            end
            n_drem[d] = drem;
            n_dquo[d] = dquo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv[0]) begin
            r_raw[0] <= i_value;
            r_x1     <= n_x1;
        end
        for (int k = 1; k < LANE_STG; k++) begin
            if (i_ctrl.adv[k]) begin
                r_raw[k] <= r_raw[k-1];
            end
        end
        if (i_ctrl.adv[1]) begin
            r_x2 <= r_x1;
            r_q0 <= n_q0;
        end
        if (i_ctrl.adv[2]) begin
            r_q <= n_q;
        end
        if (i_ctrl.adv[3]) begin
            r_drem[0] <= n_num;
            r_dquo[0] <= 8'd0;
        end
        for (int d = 0; d < DIV_STG; d++) begin
            if (i_ctrl.adv[4+d]) begin
                r_drem[d+1] <= n_drem[d];
                r_dquo[d+1] <= n_dquo[d];
            end
        end
    end

    assign o_quo = r_dquo[DIV_STG];
    assign o_raw = r_raw[LANE_STG-1];

endmodule

// ===== design/odq_merge.sv =====
// odq_merge: output register that joins the three lane results and alpha,
// selecting pass-through, forced zero or quantized color. Depends on odq_pkg.

module odq_merge import odq_pkg::*; (
    input  logic                    i_clk,
    input  t_merge_ctrl             i_ctrl,
    input  logic [CH_NUM-1:0][7:0]  i_quo,
    input  logic [CH_NUM-1:0][7:0]  i_raw,
    input  logic [7:0]              i_alpha,
    output t_pix_out                o_data
);

    logic [CH_NUM-1:0][7:0] chan;
    t_pix_out               r_out;

    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            if (!i_ctrl.quant_en) begin
                chan[c] = i_raw[c];
            end else if (i_ctrl.zero_out) begin
                chan[c] = 8'd0;
            end else begin
                chan[c] = i_quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_out.red_out   <= chan[0];
            r_out.green_out <= chan[1];
            r_out.blue_out  <= chan[2];
            r_out.alpha_out <= i_alpha;
        end
    end

    assign o_data = r_out;

endmodule

// ===== design/ordered_dither_color_quantizer_core.sv =====
// Ordered-dither color quantizer, top level.
// A result is valid once it has passed the input, lane and output stages.
// Throughput: one pixel per cycle unless output stalls; a stage advances when
// empty or its successor moves; bubbles collapse, input enters while output holds.
// Reset (synchronous, active low) empties the pipeline and sets quantize off,
// 2 levels and a zero dither scale. Uses odq_pkg, odq_lane, odq_merge.

module ordered_dither_color_quantizer_core import odq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pix_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pix_out    o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    logic                   r_quant_en;
    logic [8:0]             r_levels;
    logic [15:0]            r_scale;
    logic [STG_NUM-1:0]     r_vld;
    logic [STG_NUM-1:0]     stg_adv;
    logic [10:0]            r_dmag;
    logic                   r_dneg;
    logic [CH_NUM-1:0][7:0] r_chan;
    logic [7:0]             r_alpha [LANE_STG+1];

    logic [3:0]             bay;
    logic                   t_neg;
    logic [3:0]             t_mag;
    logic [19:0]            prod;
    t_lane_ctrl             lane_ctrl;
    t_merge_ctrl            merge_ctrl;
    logic [CH_NUM-1:0][7:0] lane_quo;
    logic [CH_NUM-1:0][7:0] lane_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_en <= 1'b0;
            r_levels   <= 9'd2;
            r_scale    <= 16'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_QUANT_EN: r_quant_en <= i_cfg_wdata[0];
                CFG_LEVELS:   r_levels   <= i_cfg_wdata[8:0];
                CFG_SCALE:    r_scale    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // per-stage advance: a stage moves when it is empty or its successor moves
    always_comb begin
        stg_adv[STG_NUM-1] = !r_vld[STG_NUM-1] || i_out_ready;
        for (int i = STG_NUM - 2; i >= 0; i--) begin
            stg_adv[i] = !r_vld[i] || stg_adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < STG_NUM; i++) begin
                if (stg_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // shared dither offset: |bayer - 7| * scale >> 8, sign kept apart
    always_comb begin
        bay   = bayer_lookup(i_in_data.dither_row, i_in_data.dither_col);
        t_neg = bay < 4'd7;
        t_mag = t_neg ? (4'd7 - bay) : (bay - 4'd7);
        prod  = 20'(t_mag) * 20'(r_scale);
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[0]) begin
            r_dmag     <= prod[18:8];
            r_dneg     <= t_neg;
            r_chan[0]  <= i_in_data.red_in;
            r_chan[1]  <= i_in_data.green_in;
            r_chan[2]  <= i_in_data.blue_in;
            r_alpha[0] <= i_in_data.alpha_in;
        end
        for (int k = 1; k <= LANE_STG; k++) begin
            if (stg_adv[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    always_comb begin
        lane_ctrl.adv  = stg_adv[LANE_STG:1];
        lane_ctrl.lm1  = r_levels - 9'd1;
        lane_ctrl.dmag = r_dmag;
        lane_ctrl.dneg = r_dneg;
        merge_ctrl.quant_en = r_quant_en;
        merge_ctrl.zero_out = r_levels <= 9'd1;
        merge_ctrl.adv      = stg_adv[STG_NUM-1];
    end

    for (genvar g = 0; g < CH_NUM; g++) begin : g_lane
        odq_lane u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (lane_ctrl),
            .i_value (r_chan[g]),
            .o_quo   (lane_quo[g]),
            .o_raw   (lane_raw[g])
        );
    end

    odq_merge u_merge (
        .i_clk   (i_clk),
        .i_ctrl  (merge_ctrl),
        .i_quo   (lane_quo),
        .i_raw   (lane_raw),
        .i_alpha (r_alpha[LANE_STG]),
        .o_data  (o_out_data)
    );

    assign o_out_valid = r_vld[STG_NUM-1];
    assign o_in_ready  = stg_adv[0];

`ifndef SYNTHESIS
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output stage can move");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("input taken into a full stalled pipeline");

    a_zero_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_quant_en && (r_levels <= 9'd1)) |->
        (o_out_data.red_out == 8'd0 && o_out_data.green_out == 8'd0 &&
         o_out_data.blue_out == 8'd0))
        else $error("nonzero color with fewer than two levels");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
